[sv/tfir_pkg.sv]
`default_nettype none

package tfir_pkg;

	localparam int TAPS         = 65;
	localparam int SAMPLE_WIDTH = 16;
	localparam int COEF_WIDTH   = 18;
	localparam int DATA_WIDTH   = ((3 * SAMPLE_WIDTH + 7) / 8) * 8;

	// Coefficient set: 0 selects the 65-tap accel set, 1 the 33-tap rotation set.
	localparam bit COEF_SET_ROTATION = 1'b0;
	localparam int ROM_FRAC          = 30;
	localparam int ACCEL_LEN         = 65;
	localparam int ROT_LEN           = 33;

	// First half of each symmetric set, scaled by 2^30.
	localparam int ACCEL_HALF [33] = '{
		0, 0, 0, 0, 0, 0, 0, 0, -2, -14, -69, -304, -1195, -4218, -13420,
		-38594, -100470, -236666, -503126, -959246, -1619036, -2352761,
		-2743496, -1944942, 1362148, 8793212, 21787726, 40903310, 65121002,
		91528333, 115690112, 132747347, 138910564
	};

	localparam int ROT_HALF [17] = '{
		0, 7, 117, 1179, 8616, 48606, 220179, 822694, 2584577, 6924347,
		15990067, 32088557, 56310217, 86816863, 118002958, 141733203, 150637447
	};

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic clear;
		logic mul_en;
	} mac_ctrl_t;

	// Coefficient of tap k at cw bits, cw - 1 fraction bits, rounded half away from zero.
	function automatic longint coef_of(input int k, input int cw);
		int     len;
		int     half;
		int     i;
		int     s;
		longint t;
		longint mag;
		begin
			len = COEF_SET_ROTATION ? ROT_LEN : ACCEL_LEN;
			half = (len + 1) / 2;
			if (k >= len) begin
				return 0;
			end
			i = (k < half) ? k : (len - 1 - k);
			t = COEF_SET_ROTATION ? longint'(ROT_HALF[i]) : longint'(ACCEL_HALF[i]);
			s = ROM_FRAC - (cw - 1);
			mag = (t < 0) ? -t : t;
			mag = (mag + (longint'(1) <<< (s - 1))) >>> s;
			return (t < 0) ? -mag : mag;
		end
	endfunction

endpackage

`default_nettype wire

[sv/three_axis_fir_filter.sv]
`default_nettype none

// Three-axis FIR low-pass filter.
// Input stream (s_*): one item is one sample; s_tdata packs x, y, z, each
// SAMPLE_WIDTH bits signed, x lowest. Output stream (m_*): one filtered item
// per input item, same packing.
// The delay line is a ring of TAPS cells, newest sample in cell 0. An
// accepted item shifts in at cell 0 and drops the oldest. The ring then
// rotates once around, one cell per cycle, while one multiplier per axis
// takes the sample leaving the last cell times the matching ROM coefficient
// and an accumulator sums the products at full width.
// The result shows on m_tvalid after the rotation, a drain state for the
// product register and the load into the output register. A new item is
// taken only once the last is handed on, as the single multiply-accumulate
// per axis walks the ring. s_tready is high only while no item is in work.
// A finished result sits in the output register; the next item is accepted
// while it waits. If the receiver stalls long enough, the next result holds
// back in the accumulators until the output register frees up.
// Reset clears the whole delay line to zero and empties the output register.
module three_axis_fir_filter #(
	parameter int TAPS         = tfir_pkg::TAPS,
	parameter int SAMPLE_WIDTH = tfir_pkg::SAMPLE_WIDTH,
	parameter int COEF_WIDTH   = tfir_pkg::COEF_WIDTH
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         s_tvalid,
	output logic                              s_tready,
	// sample_x, sample_y, sample_z from the lowest bit up, zero pad on top
	input  wire logic [((3*SAMPLE_WIDTH+7)/8)*8-1:0] s_tdata,
	output logic                              m_tvalid,
	input  wire logic                         m_tready,
	// filtered_x, filtered_y, filtered_z from the lowest bit up, zero pad on top
	output logic      [((3*SAMPLE_WIDTH+7)/8)*8-1:0] m_tdata
);

	localparam int DATA_W = ((3 * SAMPLE_WIDTH + 7) / 8) * 8;
	localparam int ITEM_W = 3 * SAMPLE_WIDTH;
	localparam int CNT_W  = $clog2(TAPS);

	tfir_pkg::state_t    state_q;
	tfir_pkg::state_t    state_d;
	tfir_pkg::mac_ctrl_t mac_ctrl;

	logic [CNT_W-1:0]  tap_q;
	logic              shift_en;
	logic              rot_en;
	logic              out_load;
	logic              out_valid_q;
	logic [ITEM_W-1:0] out_q;
	logic [ITEM_W-1:0] filtered;

	logic [ITEM_W-1:0]            ring [TAPS];
	logic signed [COEF_WIDTH-1:0] coef_rom [TAPS];

	// Coefficient table, built at elaboration.
	for (genvar k = 0; k < TAPS; k++) begin : g_rom
		assign coef_rom[k] = COEF_WIDTH'(tfir_pkg::coef_of(k, COEF_WIDTH));
	end

	// Ring of cells: cell 0 takes the new item on shift, the last cell on rotate.
	for (genvar k = 0; k < TAPS; k++) begin : g_cell
		logic [ITEM_W-1:0] d;
		if (k == 0) begin : g_head
			assign d = shift_en ? s_tdata[ITEM_W-1:0] : ring[TAPS-1];
		end else begin : g_body
			assign d = ring[k-1];
		end
		tfir_cell #(
			.WIDTH (ITEM_W)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (shift_en | rot_en),
			.d      (d),
			.q      (ring[k])
		);
	end

	// One multiply-accumulate per axis on the sample leaving the ring.
	for (genvar a = 0; a < 3; a++) begin : g_axis
		tfir_mac #(
			.TAPS         (TAPS),
			.SAMPLE_WIDTH (SAMPLE_WIDTH),
			.COEF_WIDTH   (COEF_WIDTH)
		) u_mac (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (mac_ctrl),
			.sample (ring[TAPS-1][a*SAMPLE_WIDTH +: SAMPLE_WIDTH]),
			.coef   (coef_rom[tap_q]),
			.result (filtered[a*SAMPLE_WIDTH +: SAMPLE_WIDTH])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tfir_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer: shift in, rotate the ring once around, drain the product stage, deliver.
	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		shift_en = 1'b0;
		rot_en   = 1'b0;
		out_load = 1'b0;
		mac_ctrl = '0;
		case (state_q)
			tfir_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					shift_en       = 1'b1;
					mac_ctrl.clear = 1'b1;
					state_d        = tfir_pkg::ST_RUN;
				end
			end
			tfir_pkg::ST_RUN: begin
				rot_en          = 1'b1;
				mac_ctrl.mul_en = 1'b1;
				if (tap_q == '0) begin
					state_d = tfir_pkg::ST_DRAIN;
				end
			end
			tfir_pkg::ST_DRAIN: begin
				state_d = tfir_pkg::ST_FINISH;
			end
			tfir_pkg::ST_FINISH: begin
				// Hold the result until the output register is free.
				if (!out_valid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = tfir_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tfir_pkg::ST_IDLE;
			end
		endcase
	end

	// Tap index: the oldest tap leaves the ring first, so count down.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_q <= '0;
		end else if (shift_en) begin
			tap_q <= CNT_W'(TAPS - 1);
		end else if (rot_en) begin
			tap_q <= tap_q - 1'b1;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= filtered;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = DATA_W'(out_q);

endmodule

`default_nettype wire

[sv/tfir_cell.sv]
`default_nettype none

// One delay-line cell: hold a three-axis sample, take the neighbor's on advance.
module tfir_cell #(
	parameter int WIDTH = 3 * tfir_pkg::SAMPLE_WIDTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire logic [WIDTH-1:0] d,
	output logic      [WIDTH-1:0] q
);

	logic [WIDTH-1:0] sample_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_q <= '0;
		end else if (en) begin
			sample_q <= d;
		end
	end

	assign q = sample_q;

endmodule

`default_nettype wire

[sv/tfir_mac.sv]
`default_nettype none

// One axis: multiply, accumulate at full width, round and saturate.
module tfir_mac #(
	parameter int TAPS         = tfir_pkg::TAPS,
	parameter int SAMPLE_WIDTH = tfir_pkg::SAMPLE_WIDTH,
	parameter int COEF_WIDTH   = tfir_pkg::COEF_WIDTH
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire tfir_pkg::mac_ctrl_t             ctrl,
	input  wire logic signed [SAMPLE_WIDTH-1:0]  sample,
	input  wire logic signed [COEF_WIDTH-1:0]    coef,
	output logic signed      [SAMPLE_WIDTH-1:0]  result
);

	localparam int PROD_W = SAMPLE_WIDTH + COEF_WIDTH;
	localparam int ACC_W  = PROD_W + $clog2(TAPS) + 1;
	localparam int FRAC   = COEF_WIDTH - 1;

	localparam logic signed [ACC_W:0] RND =
		{{(ACC_W + 1 - FRAC){1'b0}}, 1'b1, {(FRAC - 1){1'b0}}};
	localparam logic signed [ACC_W:0] SAT_HI =
		(ACC_W + 1)'((longint'(1) <<< (SAMPLE_WIDTH - 1)) - 1);
	localparam logic signed [ACC_W:0] SAT_LO = -SAT_HI - 1;

	logic signed [PROD_W-1:0] prod_s1;
	logic                     prod_valid_s1;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W:0]    rnd;
	logic signed [ACC_W:0]    shifted;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_valid_s1 <= 1'b0;
		end else begin
			prod_valid_s1 <= ctrl.mul_en;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.mul_en) begin
			prod_s1 <= sample * coef;
		end
		if (ctrl.clear) begin
			acc_q <= '0;
		end else if (prod_valid_s1) begin
			acc_q <= acc_q + ACC_W'(prod_s1);
		end
	end

	// Add half an LSB, then floor-shift: exact halves round up.
	assign rnd     = (ACC_W + 1)'(acc_q) + RND;
	assign shifted = rnd >>> FRAC;

	always_comb begin
		if (shifted > SAT_HI) begin
			result = SAT_HI[SAMPLE_WIDTH-1:0];
		end else if (shifted < SAT_LO) begin
			result = SAT_LO[SAMPLE_WIDTH-1:0];
		end else begin
			result = shifted[SAMPLE_WIDTH-1:0];
		end
	end

endmodule

`default_nettype wire

[sv/tfir_checker.sv]
`default_nettype none

module tfir_checker #(
	parameter int DATA_W = tfir_pkg::DATA_WIDTH
) (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              s_tvalid,
	input wire logic              s_tready,
	input wire logic              m_tvalid,
	input wire logic              m_tready,
	input wire logic [DATA_W-1:0] m_tdata
);

	// A stalled result stays offered.
	a_out_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	// A stalled result keeps its data.
	a_out_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result changed while stalled");

	// An item in work blocks the input.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input ready right after an accepted item");

	// A result never appears in the cycle right after an accept.
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !$rose(m_tvalid))
		else $error("result appeared without filter latency");

	// Delivering a result frees the input side.
	a_ready_on_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> s_tready)
		else $error("input not ready when a result is delivered");

endmodule

bind three_axis_fir_filter tfir_checker #(
	.DATA_W (DATA_W)
) u_tfir_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
